// ===== hw/rtl/vwsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Variable-width shift/rotate unit package
// Shared widths, operation codes and the records that move between stages.
// ----------------------------------------------------------------------------
package vwsr_pkg;

  localparam int DATA_W      = 64;
  localparam int SIZE_W      = 7;
  localparam int SHIFT_W     = 6;
  localparam int ROT_W       = DATA_W + 1;
  localparam int BYTE_W      = 8;
  localparam int GROUPS      = DATA_W / BYTE_W;
  localparam int GRP_CNT_W   = 3;
  localparam int QUOT_W      = 6;
  localparam int DIV_W       = SIZE_W + QUOT_W;
  localparam int PREP_STEPS  = 3;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 80;

  localparam logic [SIZE_W-1:0] FULL_SIZE = SIZE_W'(DATA_W);

  typedef enum logic [3:0] {
    OP_ASR      = 4'd0,
    OP_SL       = 4'd1,
    OP_SR       = 4'd2,
    OP_RL       = 4'd3,
    OP_RR       = 4'd4,
    OP_RLC      = 4'd5,
    OP_RRC      = 4'd6,
    OP_CLZ      = 4'd7,
    OP_CTZ      = 4'd8,
    OP_MIRROR   = 4'd9,
    OP_BYTESWAP = 4'd10,
    OP_HALFSWAP = 4'd11
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [SIZE_W-1:0] ws;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] w;
    logic [SHIFT_W-1:0] n;
    logic              c;
    logic [SIZE_W-1:0] m;
    logic [SIZE_W-1:0] r;
  } prep_t;

  typedef struct packed {
    op_t                              op;
    logic [SIZE_W-1:0]                ws;
    logic [DATA_W-1:0]                mask;
    logic [DATA_W-1:0]                w;
    logic [DATA_W-1:0]                w_se;
    logic [SHIFT_W-1:0]               n;
    logic                             c;
    logic [ROT_W-1:0]                 v;
    logic [SIZE_W-1:0]                m;
    logic [SIZE_W-1:0]                lsh;
    logic [SIZE_W-1:0]                rsh;
    logic [DATA_W-1:0]                mirror;
    logic [DATA_W-1:0]                swapped;
    logic [SIZE_W-1:0]                swap_size;
    logic [GROUPS-1:0]                grp_nz;
    logic [GROUPS-1:0][GRP_CNT_W-1:0] grp_cnt;
  } scan_t;

  typedef struct packed {
    logic [SIZE_W-1:0] new_word_size;
    logic [SIZE_W-1:0] bit_count;
    logic              carry_out;
    logic [DATA_W-1:0] result_word;
  } res_t;

endpackage

// ===== hw/rtl/vwsr_prep.sv =====
// ----------------------------------------------------------------------------
// Stage 1: operand preparation
// Clamps the word size, masks the operand and starts the count reduction.
// ----------------------------------------------------------------------------
module vwsr_prep #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic                         in_valid,
  input  logic [3:0]                   opcode,
  input  logic [vwsr_pkg::DATA_W-1:0]  operand_word,
  input  logic [vwsr_pkg::SHIFT_W-1:0] shift_count,
  input  logic                         carry_in,
  input  logic [vwsr_pkg::SIZE_W-1:0]  word_size,
  output logic                         out_valid,
  output vwsr_pkg::prep_t              out_data
);

  localparam logic [vwsr_pkg::SIZE_W-1:0] MAX_SIZE = vwsr_pkg::SIZE_W'(MAX_WIDTH);

  vwsr_pkg::prep_t                   data_next;
  logic [vwsr_pkg::SIZE_W-1:0]       ws;
  logic [vwsr_pkg::SIZE_W-1:0]       r;
  logic [vwsr_pkg::DIV_W-1:0]        dvs;

  always_comb begin
    if (word_size == '0) begin
      ws = vwsr_pkg::SIZE_W'(1);
    end else if (word_size > MAX_SIZE) begin
      ws = MAX_SIZE;
    end else begin
      ws = word_size;
    end
  end

  // The count is reduced modulo the rotate span by restoring subtraction;
  // the upper quotient bits are settled here, the rest in the next stage.
  always_comb begin
    data_next.op   = vwsr_pkg::op_t'(opcode);
    data_next.ws   = ws;
    data_next.mask = ~({vwsr_pkg::DATA_W{1'b1}} << ws);
    data_next.w    = operand_word & data_next.mask;
    data_next.n    = shift_count;
    data_next.c    = carry_in;
    if (data_next.op == vwsr_pkg::OP_RLC || data_next.op == vwsr_pkg::OP_RRC) begin
      data_next.m = ws + vwsr_pkg::SIZE_W'(1);
    end else begin
      data_next.m = ws;
    end
    r   = vwsr_pkg::SIZE_W'(shift_count);
    dvs = '0;
    for (int k = vwsr_pkg::QUOT_W - 1; k >= vwsr_pkg::QUOT_W - vwsr_pkg::PREP_STEPS; k--) begin
      dvs = vwsr_pkg::DIV_W'(data_next.m) << k;
      if (vwsr_pkg::DIV_W'(r) >= dvs) begin
        r = r - vwsr_pkg::SIZE_W'(dvs);
      end
    end
    data_next.r = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== hw/rtl/vwsr_scan.sv =====
// ----------------------------------------------------------------------------
// Stage 2: count reduction, reversal and zero scan
// Finishes the rotate amount, builds mirrored and swapped words and the
// per-byte zero flags used for the leading and trailing zero counts.
// ----------------------------------------------------------------------------
module vwsr_scan (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  logic            in_valid,
  input  vwsr_pkg::prep_t in_data,
  output logic            out_valid,
  output vwsr_pkg::scan_t out_data
);

  localparam int HALF_W = 2 * vwsr_pkg::BYTE_W;

  vwsr_pkg::scan_t                   data_next;
  logic [vwsr_pkg::SIZE_W-1:0]       r;
  logic [vwsr_pkg::DIV_W-1:0]        dvs;
  logic [vwsr_pkg::SHIFT_W-1:0]      top_idx;
  logic [vwsr_pkg::DATA_W-1:0]       rev_bits;
  logic [vwsr_pkg::DATA_W-1:0]       rev_bytes;
  logic [vwsr_pkg::DATA_W-1:0]       rev_halves;
  logic [vwsr_pkg::SIZE_W-1:0]       byte_size;
  logic [vwsr_pkg::SIZE_W-1:0]       half_size;
  logic [vwsr_pkg::DATA_W-1:0]       scan_src;
  logic                              thru_carry;

  always_comb begin
    for (int i = 0; i < vwsr_pkg::DATA_W; i++) begin
      rev_bits[i] = in_data.w[vwsr_pkg::DATA_W-1-i];
    end
    for (int i = 0; i < vwsr_pkg::DATA_W / vwsr_pkg::BYTE_W; i++) begin
      rev_bytes[i*vwsr_pkg::BYTE_W +: vwsr_pkg::BYTE_W] =
        in_data.w[(vwsr_pkg::DATA_W/vwsr_pkg::BYTE_W-1-i)*vwsr_pkg::BYTE_W +: vwsr_pkg::BYTE_W];
    end
    for (int i = 0; i < vwsr_pkg::DATA_W / HALF_W; i++) begin
      rev_halves[i*HALF_W +: HALF_W] =
        in_data.w[(vwsr_pkg::DATA_W/HALF_W-1-i)*HALF_W +: HALF_W];
    end
  end

  always_comb begin
    // Byte swap needs at least two bytes, halfword swap two halfwords.
    if (in_data.ws < vwsr_pkg::SIZE_W'(HALF_W)) begin
      byte_size = vwsr_pkg::SIZE_W'(HALF_W);
    end else begin
      byte_size = (in_data.ws + vwsr_pkg::SIZE_W'(vwsr_pkg::BYTE_W - 1)) &
                  ~vwsr_pkg::SIZE_W'(vwsr_pkg::BYTE_W - 1);
    end
    if (in_data.ws < vwsr_pkg::SIZE_W'(2 * HALF_W)) begin
      half_size = vwsr_pkg::SIZE_W'(2 * HALF_W);
    end else begin
      half_size = (in_data.ws + vwsr_pkg::SIZE_W'(HALF_W - 1)) &
                  ~vwsr_pkg::SIZE_W'(HALF_W - 1);
    end
  end

  always_comb begin
    r   = in_data.r;
    dvs = '0;
    for (int k = vwsr_pkg::QUOT_W - vwsr_pkg::PREP_STEPS - 1; k >= 0; k--) begin
      dvs = vwsr_pkg::DIV_W'(in_data.m) << k;
      if (vwsr_pkg::DIV_W'(r) >= dvs) begin
        r = r - vwsr_pkg::SIZE_W'(dvs);
      end
    end

    top_idx    = vwsr_pkg::SHIFT_W'(in_data.ws - vwsr_pkg::SIZE_W'(1));
    thru_carry = (in_data.op == vwsr_pkg::OP_RLC) || (in_data.op == vwsr_pkg::OP_RRC);

    data_next.op   = in_data.op;
    data_next.ws   = in_data.ws;
    data_next.mask = in_data.mask;
    data_next.w    = in_data.w;
    data_next.w_se = in_data.w | (in_data.w[top_idx] ? ~in_data.mask : '0);
    data_next.n    = in_data.n;
    data_next.c    = in_data.c;
    data_next.m    = in_data.m;
    data_next.v    = vwsr_pkg::ROT_W'(in_data.w) |
                     ((thru_carry && in_data.c) ?
                      (vwsr_pkg::ROT_W'(1) << in_data.ws) : '0);

    // A right rotate is carried out as a left rotate by the complement.
    if (in_data.op == vwsr_pkg::OP_RL || in_data.op == vwsr_pkg::OP_RLC) begin
      data_next.lsh = r;
      data_next.rsh = in_data.m - r;
    end else begin
      data_next.lsh = in_data.m - r;
      data_next.rsh = r;
    end

    data_next.mirror = rev_bits >> (vwsr_pkg::FULL_SIZE - in_data.ws);
    if (in_data.op == vwsr_pkg::OP_BYTESWAP) begin
      data_next.swap_size = byte_size;
      data_next.swapped   = rev_bytes >> (vwsr_pkg::FULL_SIZE - byte_size);
    end else begin
      data_next.swap_size = half_size;
      data_next.swapped   = rev_halves >> (vwsr_pkg::FULL_SIZE - half_size);
    end

    // Leading zeros are the trailing zeros of the mirrored word.
    scan_src = (in_data.op == vwsr_pkg::OP_CLZ) ? data_next.mirror : in_data.w;
    for (int g = 0; g < vwsr_pkg::GROUPS; g++) begin
      data_next.grp_nz[g]  = |scan_src[g*vwsr_pkg::BYTE_W +: vwsr_pkg::BYTE_W];
      data_next.grp_cnt[g] = '0;
      for (int i = vwsr_pkg::BYTE_W - 1; i >= 0; i--) begin
        if (scan_src[g*vwsr_pkg::BYTE_W + i]) begin
          data_next.grp_cnt[g] = vwsr_pkg::GRP_CNT_W'(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== hw/rtl/vwsr_exec.sv =====
// ----------------------------------------------------------------------------
// Stage 3: shift execution and result select
// Runs the barrel shifts and rotates, merges the zero scan and registers
// the finished result.
// ----------------------------------------------------------------------------
module vwsr_exec (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  logic            in_valid,
  input  vwsr_pkg::scan_t in_data,
  output logic            out_valid,
  output vwsr_pkg::res_t  out_data
);

  vwsr_pkg::res_t                      data_next;
  logic [2*vwsr_pkg::DATA_W-1:0]       sl_wide;
  logic [vwsr_pkg::ROT_W-1:0]          rot_mask;
  logic [vwsr_pkg::ROT_W-1:0]          rot;
  logic [vwsr_pkg::SHIFT_W-1:0]        last_idx;
  logic [vwsr_pkg::SHIFT_W-1:0]        top_idx;
  logic [vwsr_pkg::SIZE_W-1:0]         zcnt;

  always_comb begin
    sl_wide  = {{vwsr_pkg::DATA_W{1'b0}}, in_data.w} << in_data.n;
    rot_mask = ~({vwsr_pkg::ROT_W{1'b1}} << in_data.m);
    rot      = ((in_data.v << in_data.lsh) | (in_data.v >> in_data.rsh)) & rot_mask;
    last_idx = in_data.n - vwsr_pkg::SHIFT_W'(1);
    top_idx  = vwsr_pkg::SHIFT_W'(in_data.ws - vwsr_pkg::SIZE_W'(1));

    // The lowest byte holding a one decides the count.
    zcnt = in_data.ws;
    for (int g = vwsr_pkg::GROUPS - 1; g >= 0; g--) begin
      if (in_data.grp_nz[g]) begin
        zcnt = vwsr_pkg::SIZE_W'(g * vwsr_pkg::BYTE_W) +
               vwsr_pkg::SIZE_W'(in_data.grp_cnt[g]);
      end
    end

    data_next.result_word   = in_data.w;
    data_next.carry_out     = in_data.c;
    data_next.bit_count     = '0;
    data_next.new_word_size = in_data.ws;

    case (in_data.op)
      vwsr_pkg::OP_ASR: begin
        data_next.result_word = vwsr_pkg::DATA_W'($signed(in_data.w_se) >>> in_data.n) &
                                in_data.mask;
        data_next.carry_out   = in_data.w_se[last_idx];
      end
      vwsr_pkg::OP_SL: begin
        data_next.result_word = sl_wide[vwsr_pkg::DATA_W-1:0] & in_data.mask;
        data_next.carry_out   = sl_wide[in_data.ws];
      end
      vwsr_pkg::OP_SR: begin
        data_next.result_word = in_data.w >> in_data.n;
        data_next.carry_out   = in_data.w[last_idx];
      end
      vwsr_pkg::OP_RL: begin
        data_next.result_word = rot[vwsr_pkg::DATA_W-1:0];
        data_next.carry_out   = rot[0];
      end
      vwsr_pkg::OP_RR: begin
        data_next.result_word = rot[vwsr_pkg::DATA_W-1:0];
        data_next.carry_out   = rot[top_idx];
      end
      vwsr_pkg::OP_RLC, vwsr_pkg::OP_RRC: begin
        data_next.result_word = rot[vwsr_pkg::DATA_W-1:0] & in_data.mask;
        data_next.carry_out   = rot[in_data.ws];
      end
      vwsr_pkg::OP_CLZ, vwsr_pkg::OP_CTZ: begin
        data_next.bit_count = zcnt;
      end
      vwsr_pkg::OP_MIRROR: begin
        data_next.result_word = in_data.mirror;
      end
      vwsr_pkg::OP_BYTESWAP, vwsr_pkg::OP_HALFSWAP: begin
        data_next.result_word   = in_data.swapped;
        data_next.new_word_size = in_data.swap_size;
      end
      default: begin
        data_next.result_word = in_data.w;
      end
    endcase

    // A zero count moves nothing, so the carry is kept.
    if (in_data.n == '0) begin
      data_next.carry_out = in_data.c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== hw/rtl/variable_width_shift_rotate_unit.sv =====
// ----------------------------------------------------------------------------
// Variable-width shift/rotate unit
// Shifts, rotates (also through carry), zero counts, bit mirror and byte or
// halfword swap at a configurable word size of 1 to 64 bits.
// ----------------------------------------------------------------------------
// The unit takes one item per clock unless a stalled output has filled the
// pipeline, and returns exactly one result for it. Each item passes three
// register stages: preparation (size clamp, operand mask and the first half
// of the count reduction), scan (rest of the reduction, bit, byte and
// halfword reversal, per-byte zero flags) and execution (barrel shifts,
// rotate, zero count merge), whose registers form the output.
// Every stage holds its item while the stage after it is full and stalled,
// and an empty stage always takes a new item, so while a finished result
// waits at the output the input still takes items until the preparation and
// scan stages are full as well. The word size register is written through
// the cfg channel, which is always ready; write it only while no item is in
// the pipeline. Sizes of 0 are used as 1 and sizes above MAX_WIDTH as
// MAX_WIDTH.
// ----------------------------------------------------------------------------
module variable_width_shift_rotate_unit #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Fields from bit 0 up: opcode[3:0], operand_word[67:4],
  // shift_count[73:68], carry_in[74], zero fill[79:75].
  input  logic [vwsr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Fields from bit 0 up: result_word[63:0], carry_out[64],
  // bit_count[71:65], new_word_size[78:72], zero fill[79].
  output logic [vwsr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [vwsr_pkg::SIZE_W-1:0]          cfg_data
);

  logic [vwsr_pkg::SIZE_W-1:0] word_size;

  logic            prep_valid;
  logic            scan_valid;
  logic            exec_valid;
  logic            prep_load;
  logic            scan_load;
  logic            exec_load;
  vwsr_pkg::prep_t prep_data;
  vwsr_pkg::scan_t scan_data;
  vwsr_pkg::res_t  exec_data;

  // The configuration channel never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_size <= vwsr_pkg::FULL_SIZE;
    end else if (cfg_valid) begin
      word_size <= cfg_data;
    end
  end

  // A stage loads when it is empty or its contents move on this cycle.
  assign exec_load     = !exec_valid || m_axis_tready;
  assign scan_load     = !scan_valid || exec_load;
  assign prep_load     = !prep_valid || scan_load;
  assign s_axis_tready = prep_load;

  vwsr_prep #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_prep (
    .clk          (clk),
    .rst          (rst),
    .load         (prep_load),
    .in_valid     (s_axis_tvalid),
    .opcode       (s_axis_tdata[3:0]),
    .operand_word (s_axis_tdata[67:4]),
    .shift_count  (s_axis_tdata[73:68]),
    .carry_in     (s_axis_tdata[74]),
    .word_size    (word_size),
    .out_valid    (prep_valid),
    .out_data     (prep_data)
  );

  vwsr_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .load      (scan_load),
    .in_valid  (prep_valid),
    .in_data   (prep_data),
    .out_valid (scan_valid),
    .out_data  (scan_data)
  );

  vwsr_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .load      (exec_load),
    .in_valid  (scan_valid),
    .in_data   (scan_data),
    .out_valid (exec_valid),
    .out_data  (exec_data)
  );

  assign m_axis_tvalid = exec_valid;
  assign m_axis_tdata  = {1'b0, exec_data};

  // An empty output stage means the pipeline can take an item.
  a_ready_when_drained : assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the output stage is empty");

  // An accepted item always lands in the first stage.
  a_accept_lands : assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> prep_valid)
    else $error("accepted item lost at the first stage");

  // The reported word size stays within the legal range.
  a_size_range : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[78:72] != '0) &&
                      (m_axis_tdata[78:72] <= vwsr_pkg::FULL_SIZE))
    else $error("reported word size out of range");

  // A zero count never exceeds the word size it was taken at.
  a_count_range : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[71:65] <= m_axis_tdata[78:72])
    else $error("bit count exceeds the word size");

endmodule

// ===== verif/variable_width_shift_rotate_unit_test.sv =====
// ----------------------------------------------------------------------------
// Variable-width shift/rotate unit testbench
// Drives items into the stream input and checks every result against a
// written-out value or a predictor of the unit, at the reset word size and
// at a series of configured sizes from below the legal range to above it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module variable_width_shift_rotate_unit_test;

  localparam int MAX_W = 64;

  // Opcodes 12 to 15 are not part of op_t. The unit passes the word through.
  localparam logic [3:0] OP_SPARE = 4'd15;

  // The receiver holds off this long once, so that the pipeline fills up and
  // the input has to stall while the sender keeps offering items.
  localparam int LONG_HOLD = 200;

  localparam int NUM_PHASES = 14;
  localparam int PHASE_ITEMS = 88;

  // Word sizes written one per phase. They cover the clamp at both ends
  // (0 and 127), the smallest and largest legal sizes, and sizes on either
  // side of the byte and halfword swap boundaries. The last phases use a
  // random size.
  localparam logic [vwsr_pkg::SIZE_W-1:0] PHASE_SIZES [12] = '{
    7'd1, 7'd0, 7'd127, 7'd8, 7'd15, 7'd16, 7'd17, 7'd31, 7'd33, 7'd48, 7'd63, 7'd64
  };

  // One directed item. When known is set, want holds the result as it can
  // be read straight off the behavior at the reset word size of 64.
  typedef struct packed {
    logic [3:0]                   opc;
    logic [vwsr_pkg::DATA_W-1:0]  word;
    logic [vwsr_pkg::SHIFT_W-1:0] steps;
    logic                         cin;
    logic                         known;
    vwsr_pkg::res_t               want;
  } probe_t;

  localparam vwsr_pkg::res_t COMPUTED = '0;

  localparam probe_t DIRECTED [24] = '{
    // Long shifts push all but one bit out: ASR leaves sign copies, SL and SR keep
    // the last bit shifted out in the carry.
    '{vwsr_pkg::OP_ASR, 64'h8000000000000000, 6'd63, 1'b0, 1'b1,
      '{7'd64, 7'd0, 1'b0, 64'hFFFFFFFFFFFFFFFF}},
    '{vwsr_pkg::OP_SL, 64'hFFFFFFFFFFFFFFFF, 6'd63, 1'b0, 1'b1,
      '{7'd64, 7'd0, 1'b1, 64'h8000000000000000}},
    '{vwsr_pkg::OP_SR, 64'hFFFFFFFFFFFFFFFF, 6'd63, 1'b0, 1'b1,
      '{7'd64, 7'd0, 1'b1, 64'h0000000000000001}},
    // A zero count leaves the word alone and keeps the carry.
    '{vwsr_pkg::OP_SL, 64'h0123456789ABCDEF, 6'd0, 1'b1, 1'b1,
      '{7'd64, 7'd0, 1'b1, 64'h0123456789ABCDEF}},
    '{vwsr_pkg::OP_RL, 64'h8000000000000001, 6'd1, 1'b0, 1'b1,
      '{7'd64, 7'd0, 1'b1, 64'h0000000000000003}},
    '{vwsr_pkg::OP_RR, 64'h8000000000000001, 6'd1, 1'b0, 1'b1,
      '{7'd64, 7'd0, 1'b1, 64'hC000000000000000}},
    '{vwsr_pkg::OP_RLC, 64'h8000000000000000, 6'd1, 1'b0, 1'b1,
      '{7'd64, 7'd0, 1'b1, 64'h0000000000000000}},
    '{vwsr_pkg::OP_RRC, 64'h0000000000000001, 6'd1, 1'b1, 1'b1,
      '{7'd64, 7'd0, 1'b1, 64'h8000000000000000}},
    // A zero word gives the full word size as its zero count.
    '{vwsr_pkg::OP_CLZ, 64'h0000000000000000, 6'd5, 1'b1, 1'b1,
      '{7'd64, 7'd64, 1'b1, 64'h0000000000000000}},
    '{vwsr_pkg::OP_CTZ, 64'h0000000000000000, 6'd0, 1'b0, 1'b1,
      '{7'd64, 7'd64, 1'b0, 64'h0000000000000000}},
    '{vwsr_pkg::OP_CLZ, 64'h0000000000000001, 6'd0, 1'b0, 1'b1,
      '{7'd64, 7'd63, 1'b0, 64'h0000000000000001}},
    '{vwsr_pkg::OP_CTZ, 64'h8000000000000000, 6'd0, 1'b1, 1'b1,
      '{7'd64, 7'd63, 1'b1, 64'h8000000000000000}},
    '{vwsr_pkg::OP_CLZ, 64'h8000000000000000, 6'd0, 1'b0, 1'b1,
      '{7'd64, 7'd0, 1'b0, 64'h8000000000000000}},
    '{vwsr_pkg::OP_MIRROR, 64'h0000000000000001, 6'd9, 1'b0, 1'b1,
      '{7'd64, 7'd0, 1'b0, 64'h8000000000000000}},
    '{vwsr_pkg::OP_BYTESWAP, 64'h0123456789ABCDEF, 6'd0, 1'b0, 1'b1,
      '{7'd64, 7'd0, 1'b0, 64'hEFCDAB8967452301}},
    '{vwsr_pkg::OP_HALFSWAP, 64'h0123456789ABCDEF, 6'd0, 1'b1, 1'b1,
      '{7'd64, 7'd0, 1'b1, 64'hCDEF89AB45670123}},
    '{OP_SPARE, 64'hFFFFFFFFFFFFFFFF, 6'd63, 1'b1, 1'b1,
      '{7'd64, 7'd0, 1'b1, 64'hFFFFFFFFFFFFFFFF}},
    '{vwsr_pkg::OP_ASR, 64'h7FF0F0F0F0F0F0F0, 6'd5, 1'b1, 1'b0, COMPUTED},
    '{vwsr_pkg::OP_RL, 64'h0F1E2D3C4B5A6978, 6'd63, 1'b0, 1'b0, COMPUTED},
    '{vwsr_pkg::OP_RR, 64'h0F1E2D3C4B5A6978, 6'd37, 1'b1, 1'b0, COMPUTED},
    '{vwsr_pkg::OP_RLC, 64'h9E3779B97F4A7C15, 6'd63, 1'b1, 1'b0, COMPUTED},
    '{vwsr_pkg::OP_RRC, 64'h9E3779B97F4A7C15, 6'd33, 1'b0, 1'b0, COMPUTED},
    '{vwsr_pkg::OP_MIRROR, 64'h0123456789ABCDEF, 6'd0, 1'b0, 1'b0, COMPUTED},
    '{vwsr_pkg::OP_SR, 64'h8000000000000000, 6'd17, 1'b1, 1'b0, COMPUTED}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Fields from bit 0 up: opcode, operand_word, shift_count, carry_in, zero fill.
  logic [vwsr_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  // Fields from bit 0 up: result_word, carry_out, bit_count, new_word_size,
  // zero fill.
  logic [vwsr_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [vwsr_pkg::SIZE_W-1:0]      cfg_data = '0;

  // The testbench's own copy of the word size register.
  logic [vwsr_pkg::SIZE_W-1:0] word_size_reg = vwsr_pkg::FULL_SIZE;

  vwsr_pkg::res_t awaited_results [$];
  int unsigned mismatch_count = 0;

  // Idle rates in percent. The sender's rate is used only by the stimulus
  // process; the receiver's is handed over with nonblocking writes.
  int unsigned src_idle_pct = 25;
  int unsigned sink_idle_pct = 25;

  // Receiver-side stall bookkeeping. A flip of hold_toggle asks for one long
  // hold-off, which the receiver then counts down on its own.
  logic        hold_toggle = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned sink_hold = 0;
  int unsigned sink_wait = 0;

  variable_width_shift_rotate_unit #(
    .MAX_WIDTH(MAX_W)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The register value clamped into 1..MAX_W, which is the width the unit
  // actually works at.
  function automatic int active_bits(input logic [vwsr_pkg::SIZE_W-1:0] size);
    int bits;
    bits = size;
    if (bits < 1) bits = 1;
    if (bits > MAX_W) bits = MAX_W;
    if (bits > vwsr_pkg::DATA_W) bits = vwsr_pkg::DATA_W;
    return bits;
  endfunction

  function automatic logic [vwsr_pkg::DATA_W-1:0] size_mask(input int bits);
    return (bits >= vwsr_pkg::DATA_W) ? '1 : (64'd1 << bits) - 64'd1;
  endfunction

  // Predicts the result of one item at the given register value. Shifts and
  // rotates are stepped one bit at a time so that the carry follows the
  // single-step rule even for counts at or past the word size.
  function automatic vwsr_pkg::res_t compute_shift_result(
    input logic [3:0]                   opc,
    input logic [vwsr_pkg::DATA_W-1:0]  word,
    input logic [vwsr_pkg::SHIFT_W-1:0] steps,
    input logic                         cin,
    input logic [vwsr_pkg::SIZE_W-1:0]  size
  );
    int bits, zeros, out_size, unit, units, i;
    logic [vwsr_pkg::DATA_W-1:0] msk, top, w, acc;
    logic c, b;
    bits = active_bits(size);
    msk = size_mask(bits);
    top = 64'd1 << (bits - 1);
    w = word & msk;
    c = cin;
    zeros = 0;
    out_size = bits;
    unit = 0;
    acc = '0;
    case (opc)
      vwsr_pkg::OP_ASR: repeat (steps) begin
        c = w[0];
        w = (w >> 1) | (w & top);
      end
      vwsr_pkg::OP_SL: repeat (steps) begin
        c = |(w & top);
        w = (w << 1) & msk;
      end
      vwsr_pkg::OP_SR: repeat (steps) begin
        c = w[0];
        w = w >> 1;
      end
      vwsr_pkg::OP_RL: repeat (steps) begin
        c = |(w & top);
        w = ((w << 1) & msk) | 64'(c);
      end
      vwsr_pkg::OP_RR: repeat (steps) begin
        c = w[0];
        w = (w >> 1) | (c ? top : '0);
      end
      vwsr_pkg::OP_RLC: repeat (steps) begin
        b = |(w & top);
        w = ((w << 1) & msk) | 64'(c);
        c = b;
      end
      vwsr_pkg::OP_RRC: repeat (steps) begin
        b = w[0];
        w = (w >> 1) | (c ? top : '0);
        c = b;
      end
      vwsr_pkg::OP_CLZ: begin
        if (w == '0) begin
          zeros = bits;
        end else begin
          i = bits - 1;
          while (!w[i]) begin
            zeros++;
            i--;
          end
        end
      end
      vwsr_pkg::OP_CTZ: begin
        if (w == '0) begin
          zeros = bits;
        end else begin
          i = 0;
          while (!w[i]) begin
            zeros++;
            i++;
          end
        end
      end
      vwsr_pkg::OP_MIRROR: begin
        for (i = 0; i < bits; i++)
          if (w[i]) acc[bits - 1 - i] = 1'b1;
        w = acc;
      end
      vwsr_pkg::OP_BYTESWAP: begin
        unit = 8;
        out_size = (bits < 16) ? 16 : ((bits + 7) / 8) * 8;
      end
      vwsr_pkg::OP_HALFSWAP: begin
        unit = 16;
        out_size = (bits < 32) ? 32 : ((bits + 15) / 16) * 16;
      end
      default: begin
      end
    endcase
    // Swaps widen the word first and then reverse its bytes or halfwords.
    if (unit != 0) begin
      if (out_size > vwsr_pkg::DATA_W) out_size = vwsr_pkg::DATA_W;
      units = out_size / unit;
      acc = '0;
      for (i = 0; i < units; i++)
        acc |= ((w >> (i * unit)) & size_mask(unit)) << ((units - 1 - i) * unit);
      w = acc;
    end
    return '{vwsr_pkg::SIZE_W'(out_size), vwsr_pkg::SIZE_W'(zeros), c, w};
  endfunction

  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [vwsr_pkg::DATA_W-1:0] got,
                                 input logic [vwsr_pkg::DATA_W-1:0] want);
    mismatch_count++;
    $display("%0t: %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Offers one item, possibly after an idle gap, and waits for it to be
  // taken. The expectation is queued at the edge that accepts the item, so
  // it uses the word size in force at that moment.
  task automatic offer_item(input logic [3:0] opc,
                            input logic [vwsr_pkg::DATA_W-1:0] word,
                            input logic [vwsr_pkg::SHIFT_W-1:0] steps,
                            input logic cin,
                            input logic known, input vwsr_pkg::res_t want);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 99) < src_idle_pct) gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata <= {5'd0, cin, steps, word, opc};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    awaited_results.push_back(known ? want
                                    : compute_shift_result(opc, word, steps, cin,
                                                           word_size_reg));
  endtask

  // Stops offering and waits until every result has come back, which also
  // means the pipeline is empty.
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_size(input logic [vwsr_pkg::SIZE_W-1:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    word_size_reg = value;
  endtask

  // Receiver: checks each accepted result against the oldest expectation,
  // then decides whether to stall on the next cycle.
  always @(posedge clk) begin
    vwsr_pkg::res_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        // The result fields sit in tdata in the same order as in res_t.
        got = m_axis_tdata[$bits(vwsr_pkg::res_t)-1:0];
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no item waiting", got.result_word, '0);
        end else begin
          want = awaited_results.pop_front();
          if (got.result_word !== want.result_word)
            report_mismatch("result_word", got.result_word, want.result_word);
          if (got.carry_out !== want.carry_out)
            report_mismatch("carry_out", 64'(got.carry_out), 64'(want.carry_out));
          if (got.bit_count !== want.bit_count)
            report_mismatch("bit_count", 64'(got.bit_count), 64'(want.bit_count));
          if (got.new_word_size !== want.new_word_size)
            report_mismatch("new_word_size", 64'(got.new_word_size),
                            64'(want.new_word_size));
        end
      end
      if (hold_seen != hold_toggle) begin
        hold_seen = hold_toggle;
        sink_hold = LONG_HOLD;
      end
      if (sink_hold != 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else if (sink_wait != 0) begin
        sink_wait--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < sink_idle_pct) begin
        sink_wait = pick_gap() - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [3:0] opc;
    logic [vwsr_pkg::DATA_W-1:0] word, span;
    logic [vwsr_pkg::SHIFT_W-1:0] steps;
    int bits;
    int unsigned kind;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items run at the reset word size of 64.
    for (int r = 0; r < $size(DIRECTED); r++)
      offer_item(DIRECTED[r].opc, DIRECTED[r].word, DIRECTED[r].steps,
                 DIRECTED[r].cin, DIRECTED[r].known, DIRECTED[r].want);
    drain_pipeline();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_size((p < $size(PHASE_SIZES)) ? PHASE_SIZES[p]
                                          : vwsr_pkg::SIZE_W'($urandom_range(0, 127)));
      // Every fourth phase runs without any idling. Phase 3 fills the
      // pipeline against a long receiver hold-off.
      src_idle_pct = (p % 4 == 1 || p == 3) ? 0 : 30;
      sink_idle_pct <= (p % 4 == 1) ? 0 : 30;
      if (p == 3) hold_toggle <= ~hold_toggle;
      bits = active_bits(word_size_reg);
      span = size_mask(bits);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        opc = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                           : 4'($urandom_range(0, 11));
        // Most words are masked to the active size, with sparse and dense
        // shapes so that zero counts and carries see a wide spread. Some
        // carry bits above the size, which the unit has to drop.
        kind = $urandom_range(0, 9);
        case (kind)
          0: word = '0;
          1: word = '1;
          2: word = 64'd1 << $urandom_range(0, bits - 1);
          3: word = ~(64'd1 << $urandom_range(0, bits - 1)) & span;
          4: word = {$urandom, $urandom} & {$urandom, $urandom} & span;
          5, 6, 7: word = {$urandom, $urandom} & span;
          default: word = {$urandom, $urandom};
        endcase
        steps = ($urandom_range(0, 2) == 0)
                  ? vwsr_pkg::SHIFT_W'($urandom_range(0, (bits < 63) ? bits + 1 : 63))
                  : vwsr_pkg::SHIFT_W'($urandom_range(0, 63));
        offer_item(opc, word, steps, 1'($urandom_range(0, 1)), 1'b0, COMPUTED);
      end
      drain_pipeline();
    end

    // Leave time for any stray result to show up.
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Far beyond the slowest correct run: every item waiting out the longest
  // gaps on both sides plus the long hold-off.
  initial begin : watchdog
    #9_600_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== variable_width_shift_rotate_unit.f =====
hw/rtl/vwsr_pkg.sv
hw/rtl/vwsr_prep.sv
hw/rtl/vwsr_scan.sv
hw/rtl/vwsr_exec.sv
hw/rtl/variable_width_shift_rotate_unit.sv
verif/variable_width_shift_rotate_unit_test.sv
